/* rtl/ultrasonic_wind_vector_accumulator_unit_defines.svh */
// Assertion macros shared by the wind vector accumulator RTL.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef ULTRASONIC_WIND_VECTOR_ACCUMULATOR_UNIT_DEFINES_SVH
`define ULTRASONIC_WIND_VECTOR_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define UWVA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UWVA_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/uwva_pkg.sv */
// Shared widths, codes, command/status types and the CORDIC angle table
// for the wind vector accumulator. No dependencies.
package uwva_pkg;

	localparam int TIME_W    = 16;
	localparam int RATIO_W   = 16;
	localparam int RATIO_FB  = 15;
	localparam int SCALE_W   = 24;
	localparam int CNT_W     = 9;
	localparam int SKIP_W    = 8;
	localparam int FRAC_BITS = 8;
	localparam int COMP_SH   = RATIO_FB - FRAC_BITS;
	localparam int COMP_W    = 26;
	localparam int SUM_W     = 40;
	localparam int SPD_IN_W  = 26;
	localparam int SQ_W      = 2 * COMP_W;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int DEN_W     = CNT_W + SCALE_W;
	localparam int DIVN_W    = SUM_W + FRAC_BITS + 2;
	localparam int DIVD_W    = DEN_W + 1;
	localparam int MEAN_W    = 26;
	localparam int SPD_W     = 25;
	localparam int DIR_W     = 15;
	localparam int IN_W      = 4 * TIME_W;
	localparam int OUT_W     = 168;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 24;
	localparam int MAX_ROUNDS = 256;
	localparam int CD_STEPS  = 20;
	localparam int CD_PRE    = 6;
	localparam int CD_W      = 36;
	localparam int ANG_W     = 25;
	localparam int ATAN_W    = 22;

	localparam logic [CFG_AW-1:0] REG_RATIO_X      = 3'd0;
	localparam logic [CFG_AW-1:0] REG_RATIO_Y      = 3'd1;
	localparam logic [CFG_AW-1:0] REG_SPEED_SCALE  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SAMPLE_COUNT = 3'd3;
	localparam logic [CFG_AW-1:0] REG_SKIP_COUNT   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_MEDIAN_MODE  = 3'd5;

	localparam logic [2:0] DIV_MX = 3'd0;
	localparam logic [2:0] DIV_MY = 3'd1;
	localparam logic [2:0] DIV_PS = 3'd2;
	localparam logic [2:0] DIV_PX = 3'd3;
	localparam logic [2:0] DIV_PY = 3'd4;

	typedef struct packed {
		logic       take_in;
		logic       comp;
		logic       filt;
		logic       square;
		logic       sqrt_start;
		logic       store_ms;
		logic       accum;
		logic       den_calc;
		logic       div_start;
		logic       div_store;
		logic [2:0] div_sel;
		logic       mean_mag;
		logic       cordic_start;
		logic       dir_store;
		logic       out_load;
	} uwva_cmd_t;

	typedef struct packed {
		logic used;
		logic batch_end;
		logic sqrt_done;
		logic div_done;
		logic cordic_done;
	} uwva_sts_t;

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0:  return 22'd2949120;
			5'd1:  return 22'd1740967;
			5'd2:  return 22'd919879;
			5'd3:  return 22'd466945;
			5'd4:  return 22'd234379;
			5'd5:  return 22'd117304;
			5'd6:  return 22'd58666;
			5'd7:  return 22'd29335;
			5'd8:  return 22'd14668;
			5'd9:  return 22'd7334;
			5'd10: return 22'd3667;
			5'd11: return 22'd1833;
			5'd12: return 22'd917;
			5'd13: return 22'd458;
			5'd14: return 22'd229;
			5'd15: return 22'd115;
			5'd16: return 22'd57;
			5'd17: return 22'd29;
			5'd18: return 22'd14;
			5'd19: return 22'd7;
			default: return '0;
		endcase
	endfunction

endpackage

/* rtl/ultrasonic_wind_vector_accumulator_unit.sv */
// Top level of the ultrasonic wind vector accumulator.
// Depends on uwva_pkg, uwva_ctrl and uwva_dp.
//
//  Channel  Signals                      Content
//  s        s_tvalid s_tready s_tdata    one request: four 16 bit flight times
//  m        m_tvalid m_tready m_tdata    one batch result
//  cfg      cfg_wen cfg_addr cfg_wdata   register writes, no read-back
//
// A skipped round bypasses the filter, the square root and accumulation; a used
// round waits on the 26-step square root. The last round of a batch also runs
// five passes of the 50-step shared divider plus a root and the CORDIC.
// Reset is asynchronous and restores registers and clears all batch state.
// A result waits in the output register; the next batch only stalls when it
// finishes before the previous result is taken.
module ultrasonic_wind_vector_accumulator_unit import uwva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// time_x_fwd, time_x_back, time_y_fwd, time_y_back
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// mean_x_speed, mean_y_speed, mean_speed, direction, peak_speed, peak_x,
	// peak_y, one zero pad bit
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              cfg_wen,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	uwva_cmd_t cmd;
	uwva_sts_t sts;

	uwva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	uwva_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

/* rtl/uwva_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
// Depends on uwva_pkg for widths.
module uwva_sqrt import uwva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CW = $clog2(ROOT_W);

	logic [SQ_W-1:0]   rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+3:0] rem2;
	logic [ROOT_W+3:0] trial;
	logic              ge;

	assign rem2  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (ge) begin
				rem_q  <= (ROOT_W+2)'(rem2 - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem2[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/uwva_div.sv */
// Restoring divider, one quotient bit per cycle, shared by means and peaks.
// Depends on uwva_pkg for widths.
module uwva_div import uwva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] num,
	input  logic [DIVD_W-1:0] den,
	output logic              done,
	output logic [DIVN_W-1:0] quo
);

	localparam int CW = $clog2(DIVN_W);

	logic [DIVN_W-1:0] nq_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] d_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W:0]   rem2;
	logic              ge;

	assign rem2 = {rem_q, nq_q[DIVN_W-1]};
	assign ge   = rem2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIVN_W-2:0], ge};
			rem_q <= ge ? DIVD_W'(rem2 - {1'b0, d_q}) : rem2[DIVD_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

/* rtl/uwva_dp.sv */
// Datapath: registers, component math, median windows, accumulators, CORDIC
// and result packing. Depends on uwva_pkg, uwva_sqrt and uwva_div.
module uwva_dp import uwva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  uwva_cmd_t         cmd,
	output uwva_sts_t         sts,
	input  logic [IN_W-1:0]   s_tdata,
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              cfg_wen,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam logic [ANG_W-1:0] DEG90    = ANG_W'(90 * 65536);
	localparam logic [ANG_W:0]   DIR_RND  = (ANG_W+1)'(512);
	localparam logic [15:0]      DIR_FULL = 16'd23040;
	localparam logic [DIVN_W-1:0] MEAN_LIM = DIVN_W'(33554432);
	localparam logic [DIVN_W-1:0] U25_MAX  = DIVN_W'(33554431);

	function automatic logic signed [COMP_W-1:0] to_comp(input logic signed [32:0] d);
		logic [31:0]       mag;
		logic [32:0]       rs;
		logic [COMP_W-1:0] m;
		mag = d[32] ? 32'(-d) : d[31:0];
		rs  = {1'b0, mag} + 33'(1 << (COMP_SH - 1));
		m   = COMP_W'(rs >> COMP_SH);
		return d[32] ? $signed(~m + 1'b1) : $signed(m);
	endfunction

	function automatic logic signed [COMP_W-1:0] med3s(input logic signed [COMP_W-1:0] a,
		input logic signed [COMP_W-1:0] b, input logic signed [COMP_W-1:0] c);
		logic signed [COMP_W-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	function automatic logic [SPD_IN_W-1:0] med3u(input logic [SPD_IN_W-1:0] a,
		input logic [SPD_IN_W-1:0] b, input logic [SPD_IN_W-1:0] c);
		logic [SPD_IN_W-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	function automatic logic [COMP_W-1:0] mag_of(input logic signed [COMP_W-1:0] v);
		return v[COMP_W-1] ? COMP_W'(-v) : COMP_W'(v);
	endfunction

	function automatic logic signed [MEAN_W-1:0] mean_sat(input logic [DIVN_W-1:0] q,
		input logic neg);
		logic [MEAN_W-1:0] m;
		if (neg) begin
			m = (q > MEAN_LIM) ? MEAN_W'(MEAN_LIM) : q[MEAN_W-1:0];
			return $signed(~m + 1'b1);
		end
		m = (q > U25_MAX) ? MEAN_W'(U25_MAX) : q[MEAN_W-1:0];
		return $signed(m);
	endfunction

	function automatic logic [SPD_W-1:0] sat25(input logic [DIVN_W-1:0] q);
		return (q > U25_MAX) ? SPD_W'(U25_MAX) : q[SPD_W-1:0];
	endfunction

	// Configuration registers.
	logic [RATIO_W-1:0] ratio_x_q, ratio_y_q;
	logic [SCALE_W-1:0] scale_q;
	logic [CNT_W-1:0]   samples_q;
	logic [SKIP_W-1:0]  skip_q;
	logic               mode_q;

	// Batch state.
	logic [CNT_W-1:0]           rc_q;
	logic                       used_q;
	logic signed [SUM_W-1:0]    sum_x_q, sum_y_q;
	logic [COMP_W-1:0]          max_x_q, max_y_q;
	logic [SPD_IN_W-1:0]        max_s_q;
	logic signed [COMP_W-1:0]   wx_q [3];
	logic signed [COMP_W-1:0]   wy_q [3];
	logic [SPD_IN_W-1:0]        ws_q [3];
	logic [1:0]                 slot_q;

	// Per-round working registers.
	logic signed [32:0]         dx_s1, dy_s1;
	logic signed [COMP_W-1:0]   cx_q, cy_q, xx_q, yy_q;
	logic [COMP_W-1:0]          ax_q, ay_q;
	logic [SQ_W-1:0]            sq_q;

	// Batch result registers.
	logic [DEN_W-1:0]           den_q;
	logic signed [MEAN_W-1:0]   mx_q, my_q;
	logic [ROOT_W-1:0]          ms_q;
	logic [DIR_W-1:0]           dir_q;
	logic [SPD_W-1:0]           ps_q, px_q, py_q;
	logic [OUT_W-1:0]           out_q;

	// CORDIC registers.
	logic signed [CD_W-1:0]     cu_q, cv_q;
	logic signed [ANG_W-1:0]    cz_q;
	logic [4:0]                 ci_q;
	logic                       cd_busy_q, cd_done_q;

	// Input decode and component products.
	logic [TIME_W-1:0]  xf, xb, yf, yb;
	logic [2*TIME_W-1:0] prod_x, prod_y;
	assign xf = s_tdata[TIME_W-1:0];
	assign xb = s_tdata[2*TIME_W-1:TIME_W];
	assign yf = s_tdata[3*TIME_W-1:2*TIME_W];
	assign yb = s_tdata[4*TIME_W-1:3*TIME_W];
	assign prod_x = xb * ratio_x_q;
	assign prod_y = yb * ratio_y_q;

	// Batch length and used count.
	logic [CNT_W-1:0]   n_eff, used_cnt;
	logic [SCALE_W-1:0] scale_eff;
	assign n_eff = (samples_q < CNT_W'(2)) ? CNT_W'(2) :
		((samples_q > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS) : samples_q);
	assign used_cnt  = (rc_q > {1'b0, skip_q}) ? rc_q - {1'b0, skip_q} : '0;
	assign scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	// Median windows with the current sample substituted.
	logic [1:0]               slot_eff;
	logic signed [COMP_W-1:0] wxn [3];
	logic signed [COMP_W-1:0] wyn [3];
	logic [SPD_IN_W-1:0]      wsn [3];
	logic signed [COMP_W-1:0] xx_n, yy_n;
	logic [ROOT_W-1:0]        root;
	logic [SPD_IN_W-1:0]      sp_n;
	assign slot_eff = (slot_q > 2'd2) ? 2'd0 : slot_q;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wxn[i] = (slot_eff == 2'(i)) ? cx_q : wx_q[i];
			wyn[i] = (slot_eff == 2'(i)) ? cy_q : wy_q[i];
			wsn[i] = (slot_eff == 2'(i)) ? root : ws_q[i];
		end
	end
	assign xx_n = mode_q ? med3s(wxn[0], wxn[1], wxn[2]) : cx_q;
	assign yy_n = mode_q ? med3s(wyn[0], wyn[1], wyn[2]) : cy_q;
	assign sp_n = mode_q ? root : med3u(wsn[0], wsn[1], wsn[2]);

	// Divider operands.
	logic [SUM_W-1:0]  abs_sx, abs_sy;
	logic [SUM_W-1:0]  div_v;
	logic [DEN_W-1:0]  div_d;
	logic [DIVN_W-1:0] div_num;
	logic [DIVD_W-1:0] div_den;
	logic [DIVN_W-1:0] quo;
	logic              div_done;
	logic              sqrt_done;
	assign abs_sx = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign abs_sy = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
	always_comb begin
		div_d = DEN_W'(scale_eff);
		case (cmd.div_sel)
			DIV_MX: begin div_v = abs_sx; div_d = den_q; end
			DIV_MY: begin div_v = abs_sy; div_d = den_q; end
			DIV_PS: div_v = SUM_W'(max_s_q);
			DIV_PX: div_v = SUM_W'(max_x_q);
			default: div_v = SUM_W'(max_y_q);
		endcase
	end
	assign div_num = (DIVN_W'(div_v) << (FRAC_BITS + 1)) + DIVN_W'(div_d);
	assign div_den = {div_d, 1'b0};

	uwva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	uwva_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (sq_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// Direction from the CORDIC angle and the signs of the means.
	logic [ANG_W-1:0] t_ang, total;
	logic [ANG_W:0]   tr;
	logic [15:0]      rnd;
	logic [DIR_W-1:0] dir_n;
	always_comb begin
		if (cz_q[ANG_W-1])
			t_ang = '0;
		else if ($unsigned(cz_q) > DEG90)
			t_ang = DEG90;
		else
			t_ang = $unsigned(cz_q);
		if (!mx_q[MEAN_W-1])
			total = !my_q[MEAN_W-1] ? t_ang : (DEG90 << 1) - t_ang;
		else
			total = my_q[MEAN_W-1] ? (DEG90 << 1) + t_ang : (DEG90 << 2) - t_ang;
		tr  = {1'b0, total} + DIR_RND;
		rnd = tr[ANG_W:10];
		if (mx_q == '0 && my_q == '0)
			dir_n = '0;
		else
			dir_n = DIR_W'((rnd >= DIR_FULL) ? rnd - DIR_FULL : rnd);
	end

	logic signed [CD_W-1:0] du, dv;
	assign du = cv_q >>> ci_q;
	assign dv = cu_q >>> ci_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_x_q <= RATIO_W'(32768);
			ratio_y_q <= RATIO_W'(32768);
			scale_q   <= SCALE_W'(256);
			samples_q <= CNT_W'(64);
			skip_q    <= SKIP_W'(4);
			mode_q    <= 1'b1;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_RATIO_X:      ratio_x_q <= cfg_wdata[RATIO_W-1:0];
				REG_RATIO_Y:      ratio_y_q <= cfg_wdata[RATIO_W-1:0];
				REG_SPEED_SCALE:  scale_q   <= cfg_wdata[SCALE_W-1:0];
				REG_SAMPLE_COUNT: samples_q <= cfg_wdata[CNT_W-1:0];
				REG_SKIP_COUNT:   skip_q    <= cfg_wdata[SKIP_W-1:0];
				REG_MEDIAN_MODE:  mode_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q    <= '0;
			used_q  <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_s_q <= '0;
			slot_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
				ws_q[i] <= '0;
			end
		end else if (cmd.out_load) begin
			rc_q    <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_s_q <= '0;
			slot_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
				ws_q[i] <= '0;
			end
		end else begin
			if (cmd.take_in) begin
				rc_q   <= rc_q + 1'b1;
				used_q <= rc_q >= {1'b0, skip_q};
			end
			if (cmd.filt && mode_q) begin
				wx_q[slot_eff] <= cx_q;
				wy_q[slot_eff] <= cy_q;
			end
			if (cmd.accum) begin
				if (!mode_q)
					ws_q[slot_eff] <= root;
				slot_q  <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 1'b1;
				sum_x_q <= sum_x_q + SUM_W'(xx_q);
				sum_y_q <= sum_y_q + SUM_W'(yy_q);
				if (sp_n > max_s_q)
					max_s_q <= sp_n;
				if (ax_q > max_x_q)
					max_x_q <= ax_q;
				if (ay_q > max_y_q)
					max_y_q <= ay_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			dx_s1 <= $signed({2'b00, xf, 15'd0}) - $signed({1'b0, prod_x});
			dy_s1 <= $signed({2'b00, yf, 15'd0}) - $signed({1'b0, prod_y});
		end
		if (cmd.comp) begin
			cx_q <= to_comp(dx_s1);
			cy_q <= to_comp(dy_s1);
		end
		if (cmd.filt) begin
			xx_q <= xx_n;
			yy_q <= yy_n;
			ax_q <= mag_of(xx_n);
			ay_q <= mag_of(yy_n);
		end
		if (cmd.mean_mag) begin
			ax_q <= mag_of(mx_q);
			ay_q <= mag_of(my_q);
		end
		if (cmd.square)
			sq_q <= ax_q * ax_q + ay_q * ay_q;
		if (cmd.den_calc)
			den_q <= DEN_W'(used_cnt) * DEN_W'(scale_eff);
		if (cmd.div_store) begin
			case (cmd.div_sel)
				DIV_MX: mx_q <= (den_q == '0) ? '0 : mean_sat(quo, sum_x_q[SUM_W-1]);
				DIV_MY: my_q <= (den_q == '0) ? '0 : mean_sat(quo, sum_y_q[SUM_W-1]);
				DIV_PS: ps_q <= sat25(quo);
				DIV_PX: px_q <= sat25(quo);
				default: py_q <= sat25(quo);
			endcase
		end
		if (cmd.store_ms)
			ms_q <= root;
		if (cmd.dir_store)
			dir_q <= dir_n;
		if (cmd.out_load)
			out_q <= {1'b0, py_q, px_q, ps_q, dir_q,
				ms_q[ROOT_W-1] ? {SPD_W{1'b1}} : ms_q[SPD_W-1:0], my_q, mx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_busy_q <= 1'b0;
			cd_done_q <= 1'b0;
			ci_q      <= '0;
		end else begin
			cd_done_q <= 1'b0;
			if (cmd.cordic_start) begin
				cd_busy_q <= 1'b1;
				ci_q      <= '0;
			end else if (cd_busy_q) begin
				ci_q <= ci_q + 1'b1;
				if (ci_q == 5'(CD_STEPS - 1)) begin
					cd_busy_q <= 1'b0;
					cd_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cordic_start) begin
			cu_q <= $signed(CD_W'(mag_of(my_q)) << CD_PRE);
			cv_q <= $signed(CD_W'(mag_of(mx_q)) << CD_PRE);
			cz_q <= '0;
		end else if (cd_busy_q) begin
			if (!cv_q[CD_W-1]) begin
				cu_q <= cu_q + du;
				cv_q <= cv_q - dv;
				cz_q <= cz_q + $signed(ANG_W'(atan_lut(ci_q)));
			end else begin
				cu_q <= cu_q - du;
				cv_q <= cv_q + dv;
				cz_q <= cz_q - $signed(ANG_W'(atan_lut(ci_q)));
			end
		end
	end

	assign sts.used        = used_q;
	assign sts.batch_end   = rc_q >= n_eff;
	assign sts.sqrt_done   = sqrt_done;
	assign sts.div_done    = div_done;
	assign sts.cordic_done = cd_done_q;
	assign m_tdata         = out_q;

endmodule

/* rtl/uwva_ctrl.sv */
// Controller state machine: sequences the datapath per round and per batch
// and owns both handshakes. Depends on uwva_pkg and the assertion macros.
`include "ultrasonic_wind_vector_accumulator_unit_defines.svh"
module uwva_ctrl import uwva_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  uwva_sts_t sts,
	output uwva_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_COMP  = 4'd1;
	localparam logic [3:0] ST_FILT  = 4'd2;
	localparam logic [3:0] ST_SQ    = 4'd3;
	localparam logic [3:0] ST_RT_GO = 4'd4;
	localparam logic [3:0] ST_RT_W  = 4'd5;
	localparam logic [3:0] ST_ACC   = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_DEN   = 4'd8;
	localparam logic [3:0] ST_DV_GO = 4'd9;
	localparam logic [3:0] ST_DV_W  = 4'd10;
	localparam logic [3:0] ST_MMAG  = 4'd11;
	localparam logic [3:0] ST_CD_GO = 4'd12;
	localparam logic [3:0] ST_CD_W  = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0] state_q, state_n;
	logic [2:0] div_idx_q;
	logic       mean_phase_q;
	logic       out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = div_idx_q;
		state_n     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_n     = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.comp = 1'b1;
				state_n  = sts.used ? ST_FILT : ST_CHK;
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				state_n  = ST_SQ;
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				state_n    = ST_RT_GO;
			end
			ST_RT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_n        = ST_RT_W;
			end
			ST_RT_W: begin
				if (sts.sqrt_done) begin
					if (mean_phase_q) begin
						cmd.store_ms = 1'b1;
						state_n      = ST_CD_GO;
					end else begin
						state_n = ST_ACC;
					end
				end
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_n   = ST_CHK;
			end
			ST_CHK: state_n = sts.batch_end ? ST_DEN : ST_IDLE;
			ST_DEN: begin
				cmd.den_calc = 1'b1;
				state_n      = ST_DV_GO;
			end
			ST_DV_GO: begin
				cmd.div_start = 1'b1;
				state_n       = ST_DV_W;
			end
			ST_DV_W: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (div_idx_q == DIV_MY)
						state_n = ST_MMAG;
					else if (div_idx_q == DIV_PY)
						state_n = ST_OUT;
					else
						state_n = ST_DV_GO;
				end
			end
			ST_MMAG: begin
				cmd.mean_mag = 1'b1;
				state_n      = ST_SQ;
			end
			ST_CD_GO: begin
				cmd.cordic_start = 1'b1;
				state_n          = ST_CD_W;
			end
			ST_CD_W: begin
				if (sts.cordic_done) begin
					cmd.dir_store = 1'b1;
					state_n       = ST_DV_GO;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			div_idx_q    <= DIV_MX;
			mean_phase_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CHK && sts.batch_end) begin
				div_idx_q    <= DIV_MX;
				mean_phase_q <= 1'b1;
			end
			if (state_q == ST_DV_W && sts.div_done && div_idx_q != DIV_PY)
				div_idx_q <= div_idx_q + 1'b1;
			if (state_q == ST_CD_W && sts.cordic_done)
				div_idx_q <= DIV_PS;
			if (cmd.out_load) begin
				mean_phase_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	`UWVA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || m_tready, "result overwritten")
	`UWVA_ASSERT_NXT(a_take_to_comp, s_tvalid && s_tready, state_q == ST_COMP, "request not processed")
	`UWVA_ASSERT_IMP(a_div_idx, state_q == ST_DV_GO, div_idx_q <= DIV_PY, "bad divide step")
	`UWVA_ASSERT_IMP(a_sqrt_wait, sts.sqrt_done, state_q == ST_RT_W, "root done while not waiting")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the ultrasonic wind vector accumulator.
// Holds a bit-exact batch predictor and scoreboard; depends on uwva_pkg and the RTL top.
`timescale 1ns / 100ps

class wind_batch_board;
	typedef struct {
		logic [25:0] mean_x;
		logic [25:0] mean_y;
		logic [24:0] mean_spd;
		logic [14:0] dir;
		logic [24:0] pk_spd;
		logic [24:0] pk_x;
		logic [24:0] pk_y;
	} batch_t;

	batch_t batch_q[$];
	int errors;
	longint rat_x, rat_y, scale, count, skip, mode;
	longint rounds, acc_x, acc_y, top_x, top_y, top_spd, slot;
	longint wx[3], wy[3], ws[3];

	function new();
		rat_x = 32768;
		rat_y = 32768;
		scale = 256;
		count = 64;
		skip = 4;
		mode = 1;
		errors = 0;
		clear();
	endfunction

	function void clear();
		rounds = 0;
		acc_x = 0;
		acc_y = 0;
		top_x = 0;
		top_y = 0;
		top_spd = 0;
		slot = 0;
		for (int i = 0; i < 3; i++) begin
			wx[i] = 0;
			wy[i] = 0;
			ws[i] = 0;
		end
	endfunction

	function void set_reg(logic [2:0] idx, logic [23:0] val);
		case (idx)
			uwva_pkg::REG_RATIO_X:      rat_x = val[15:0];
			uwva_pkg::REG_RATIO_Y:      rat_y = val[15:0];
			uwva_pkg::REG_SPEED_SCALE:  scale = val;
			uwva_pkg::REG_SAMPLE_COUNT: count = val[8:0];
			uwva_pkg::REG_SKIP_COUNT:   skip = val[7:0];
			uwva_pkg::REG_MEDIAN_MODE:  mode = val[0];
			default: ;
		endcase
	endfunction

	function longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function longint root(longint n);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function longint component(longint f, longint b, longint ratio);
		longint d, m;
		d = (f << 15) - b * ratio;
		m = (mag(d) + 64) >> 7;
		m = d < 0 ? -m : m;
		if (m > 33554431) m = 33554431;
		if (m < -33554432) m = -33554432;
		return m;
	endfunction

	function longint med3(longint a, longint b, longint c);
		longint lo, hi, m;
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		m = hi < c ? hi : c;
		return lo > m ? lo : m;
	endfunction

	function longint div_rnd(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	function longint mean(longint s, longint den);
		longint q;
		if (den == 0)
			return 0;
		q = div_rnd(mag(s) << 8, den);
		if (q > 33554432) q = 33554432;
		q = s < 0 ? -q : q;
		if (q > 33554431) q = 33554431;
		return q;
	endfunction

	function longint peak(longint v, longint sc);
		longint q;
		q = div_rnd(v << 8, sc);
		return q > 33554431 ? 33554431 : q;
	endfunction

	function longint heading(longint x, longint y);
		longint u, v, z, du, dv, t, tot;
		if (x == 0 && y == 0)
			return 0;
		u = mag(y) << 6;
		v = mag(x) << 6;
		z = 0;
		for (int i = 0; i < 20; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (v >= 0) begin
				u = u + du;
				v = v - dv;
				z = z + uwva_pkg::atan_lut(5'(i));
			end else begin
				u = u - du;
				v = v + dv;
				z = z - uwva_pkg::atan_lut(5'(i));
			end
		end
		t = z < 0 ? 0 : (z > 5898240 ? 5898240 : z);
		if (x >= 0)
			tot = y >= 0 ? t : 11796480 - t;
		else
			tot = y < 0 ? 11796480 + t : 23592960 - t;
		tot = (tot + 512) >> 10;
		if (tot >= 23040)
			tot = tot - 23040;
		return tot;
	endfunction

	function void note(logic [63:0] d);
		longint n, idx, cx, cy, xx, yy, ax, ay, sp, sc, used, mx, my;
		batch_t b;
		n = count < 2 ? 2 : (count > 256 ? 256 : count);
		idx = rounds;
		rounds++;
		if (idx >= skip) begin
			cx = component(d[15:0], d[31:16], rat_x);
			cy = component(d[47:32], d[63:48], rat_y);
			if (mode != 0) begin
				wx[slot] = cx;
				wy[slot] = cy;
				xx = med3(wx[0], wx[1], wx[2]);
				yy = med3(wy[0], wy[1], wy[2]);
				ax = mag(xx);
				ay = mag(yy);
				sp = root(ax * ax + ay * ay);
			end else begin
				xx = cx;
				yy = cy;
				ax = mag(xx);
				ay = mag(yy);
				ws[slot] = root(ax * ax + ay * ay);
				sp = med3(ws[0], ws[1], ws[2]);
			end
			slot = slot == 2 ? 0 : slot + 1;
			acc_x += xx;
			acc_y += yy;
			if (sp > top_spd) top_spd = sp;
			if (ax > top_x) top_x = ax;
			if (ay > top_y) top_y = ay;
		end
		if (rounds >= n) begin
			sc = scale == 0 ? 1 : scale;
			used = rounds > skip ? rounds - skip : 0;
			mx = mean(acc_x, used * sc);
			my = mean(acc_y, used * sc);
			sp = root(mx * mx + my * my);
			b.mean_x = mx[25:0];
			b.mean_y = my[25:0];
			b.mean_spd = sp > 33554431 ? 25'h1FFFFFF : sp[24:0];
			b.dir = 15'(heading(mx, my));
			b.pk_spd = 25'(peak(top_spd, sc));
			b.pk_x = 25'(peak(top_x, sc));
			b.pk_y = 25'(peak(top_y, sc));
			batch_q.push_back(b);
			clear();
		end
	endfunction

	function void check(logic [167:0] r);
		batch_t e;
		if (batch_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result %h", r);
			return;
		end
		e = batch_q.pop_front();
		if (r[25:0] !== e.mean_x || r[51:26] !== e.mean_y || r[76:52] !== e.mean_spd ||
			r[91:77] !== e.dir || r[116:92] !== e.pk_spd || r[141:117] !== e.pk_x ||
			r[166:142] !== e.pk_y) begin
			errors++;
			if (errors <= 10)
				$display("mismatch exp mx=%h my=%h ms=%h dir=%h ps=%h px=%h py=%h got %h",
					e.mean_x, e.mean_y, e.mean_spd, e.dir, e.pk_spd, e.pk_x, e.pk_y,
					r[166:0]);
		end
	endfunction
endclass

module tb_top;
	import uwva_pkg::*;

	localparam longint LIMIT = 1500000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_wen;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	wind_batch_board board;
	longint cycles;
	int sent;
	bit calm;
	bit hold_req;
	bit hold_done;
	int hold_cnt;

	ultrasonic_wind_vector_accumulator_unit DUT (.*);

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_wen = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cycles = 0;
		calm = 0;
		hold_req = 0;
		hold_done = 0;
		hold_cnt = 0;
		board = new();
	end

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			board.check(m_tdata);
	end

	// Output side: random back-pressure plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= 3000;
			hold_done <= 1;
			m_tready <= 0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 35);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_wen <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.set_reg(idx, val);
		cfg_wen <= 0;
	endtask

	task automatic load_regs(input logic [15:0] rx, input logic [15:0] ry,
		input logic [23:0] sc, input logic [8:0] cnt, input logic [7:0] sk, input bit md);
		write_reg(REG_RATIO_X, 24'(rx));
		write_reg(REG_RATIO_Y, 24'(ry));
		write_reg(REG_SPEED_SCALE, sc);
		write_reg(REG_SAMPLE_COUNT, 24'(cnt));
		write_reg(REG_SKIP_COUNT, 24'(sk));
		write_reg(REG_MEDIAN_MODE, 24'(md));
	endtask

	task automatic send_round(input logic [63:0] d);
		while (!calm && $urandom_range(99) < 35) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.batch_q.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_round();
		logic [15:0] f, g;
		if ($urandom_range(9) < 4)
			return {$urandom, $urandom};
		f = 16'($urandom_range(20000, 45000));
		g = 16'($urandom_range(20000, 45000));
		return {16'(g + $urandom_range(400) - 200), g, 16'(f + $urandom_range(400) - 200), f};
	endfunction

	task automatic run_rounds(input int k);
		for (int i = 0; i < k; i++)
			send_round(rand_round());
	endtask

	initial begin
		int cnt, sk;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		load_regs(16'd32768, 16'd32768, 24'd256, 9'd5, 8'd1, 1'b1);
		send_round(64'h0);
		send_round(64'hFFFF_FFFF_FFFF_FFFF);
		send_round(64'h0000_FFFF_0000_FFFF);
		send_round(64'hFFFF_0000_FFFF_0000);
		send_round(64'h0000_FFFF_FFFF_0000);
		send_round(64'hFFFF_0000_0000_FFFF);
		send_round(64'h5555_AAAA_AAAA_5555);
		drain();
		write_reg(REG_MEDIAN_MODE, 24'd0);
		send_round(64'hAAAA_5555_5555_AAAA);
		send_round(64'h0000_FFFF_0000_FFFF);
		send_round(64'hFFFF_0000_FFFF_0000);
		drain();
		load_regs(16'd65535, 16'd0, 24'd16777215, 9'd4, 8'd0, 1'b0);
		send_round(64'h0000_FFFF_0000_FFFF);
		send_round(64'hFFFF_0000_FFFF_0000);
		send_round(64'h1234_8000_4321_0001);
		send_round(64'hFFFF_FFFF_FFFF_FFFF);
		drain();
		load_regs(16'd0, 16'd65535, 24'd0, 9'd0, 8'd0, 1'b1);
		send_round(64'h0000_0000_0000_FFFF);
		send_round(64'hFFFF_0000_FFFF_0000);
		drain();
		load_regs(16'd40000, 16'd25000, 24'd300, 9'd3, 8'd3, 1'b1);
		run_rounds(6);
		drain();

		calm = 1;
		load_regs(16'd32768, 16'd32768, 24'd256, 9'd64, 8'd4, 1'b1);
		run_rounds(64);
		calm = 0;
		drain();

		load_regs(16'd0, 16'd65535, 24'd1, 9'd2, 8'd0, 1'b0);
		hold_req = 1;
		run_rounds(40);
		drain();

		load_regs(16'd65535, 16'd0, 24'd16777215, 9'd511, 8'd255, 1'b1);
		run_rounds(256);
		drain();

		while (sent < 620) begin
			cnt = $urandom_range(2, 12);
			sk = $urandom_range(9) == 0 ? $urandom_range(cnt, 15) : $urandom_range(cnt - 1);
			load_regs(16'($urandom), 16'($urandom),
				24'($urandom_range(9) == 0 ? $urandom : $urandom_range(1, 2000)),
				9'(cnt), 8'(sk), 1'($urandom_range(1)));
			run_rounds(cnt * $urandom_range(1, 4) + ($urandom_range(4) == 0 ? 1 : 0));
			drain();
		end

		repeat (1000) @(posedge clk);
		if (board.errors == 0 && board.batch_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
